### design/lcm_pkg.sv
// Shared constants, types and a function for the bicolor LED matrix scanner.
// Holds item kind codes, plane geometry and the column select table.
// Has no dependencies; the top level refers to it by scoped names.
package lcm_pkg;

    // Plane geometry: one byte per column, bit n is row n.
    localparam int COLUMN_COUNT = 8;
    localparam int COL_W        = $clog2(COLUMN_COUNT);
    localparam int ROW_W        = 3;
    localparam int PLANE_W      = 8;
    localparam int WORD_W       = 2 * PLANE_W;

    // Item kinds carried in the input tuser field.
    typedef enum logic [1:0] {
        FUNC_WRITE_COL = 2'd0,
        FUNC_WRITE_PIX = 2'd1,
        FUNC_CLEAR     = 2'd2,
        FUNC_SCAN_TICK = 2'd3
    } t_func;

    // Position of an output byte within one scan tick.
    typedef enum logic [1:0] {
        BYTE_SELECT = 2'd0,
        BYTE_EVEN   = 2'd1,
        BYTE_ODD    = 2'd2
    } t_byte_pos;

    // Row interleave masks.
    localparam logic [PLANE_W-1:0] EVEN_MASK = 8'h55;
    localparam logic [PLANE_W-1:0] ODD_MASK  = 8'hAA;

    // Active-low column select byte for the scanned column.
    function automatic logic [PLANE_W-1:0] col_select(input logic [COL_W-1:0] col);
        logic [PLANE_W-1:0] sel;
        case (col)
            3'd0:    sel = 8'hF7;
            3'd1:    sel = 8'h7F;
            3'd2:    sel = 8'hFE;
            3'd3:    sel = 8'hBF;
            3'd4:    sel = 8'hFD;
            3'd5:    sel = 8'hDF;
            3'd6:    sel = 8'hFB;
            3'd7:    sel = 8'hEF;
            default: sel = 8'hFF;
        endcase
        return sel;
    endfunction

endpackage

### design/lcm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Width and depth are parameters; no reset on the stored data.
// Has no dependencies.
module lcm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/bicolor_led_matrix_scanner.sv
// Bicolor 8x8 LED matrix scanner: frame planes in one RAM word per column.
// Column write and clear complete on acceptance; a pixel write reads the column, then writes it back.
// A scan tick reads the column, then S_FETCH registers the column select byte as the first
// output byte; the even and odd row bytes follow, one per cycle while the sink is ready.
// The next request is taken only after the previous one has finished.
// Reset (synchronous, active low) marks every column blank, selects column 0, msb first.
module bicolor_led_matrix_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // column_index[2:0], row_index[5:3], red_bits[13:6], green_bits[21:14],
    // pixel_color[23:22]
    input  logic [23:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // shift_byte[7:0]
    output logic [7:0]  m_axis_tdata,
    // lsb_first[0], latch_pulse[1]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PIX   = 4'b0010,
        S_FETCH = 4'b0100,
        S_SEND  = 4'b1000
    } t_state;

    // Unpacked request fields.
    logic [lcm_pkg::COL_W-1:0]   in_col;
    logic [lcm_pkg::ROW_W-1:0]   in_row;
    logic [lcm_pkg::PLANE_W-1:0] in_red;
    logic [lcm_pkg::PLANE_W-1:0] in_green;
    logic [1:0]                  in_color;
    lcm_pkg::t_func              in_func;

    assign in_col   = s_axis_tdata[2:0];
    assign in_row   = s_axis_tdata[5:3];
    assign in_red   = s_axis_tdata[13:6];
    assign in_green = s_axis_tdata[21:14];
    assign in_color = s_axis_tdata[23:22];
    assign in_func  = lcm_pkg::t_func'(s_axis_tuser);

    // Control and payload registers.
    t_state                            r_state, n_state;
    logic [lcm_pkg::COLUMN_COUNT-1:0]  r_valid, n_valid;
    logic                              r_hit, n_hit;
    logic [lcm_pkg::COL_W-1:0]         r_scan_col, n_scan_col;
    logic                              r_lsb, n_lsb;
    logic [lcm_pkg::COL_W-1:0]         r_col, n_col;
    logic [lcm_pkg::ROW_W-1:0]         r_row, n_row;
    logic [1:0]                        r_color, n_color;
    logic [lcm_pkg::PLANE_W-1:0]       r_even, n_even;
    logic [lcm_pkg::PLANE_W-1:0]       r_odd, n_odd;
    lcm_pkg::t_byte_pos                r_pos, n_pos;
    logic                              r_m_valid, n_m_valid;
    logic [lcm_pkg::PLANE_W-1:0]       r_m_data, n_m_data;
    logic [1:0]                        r_m_user, n_m_user;
    logic                              r_m_last, n_m_last;

    // RAM ports.
    logic                          ram_we;
    logic [lcm_pkg::COL_W-1:0]     ram_waddr;
    logic [lcm_pkg::WORD_W-1:0]    ram_wdata;
    logic [lcm_pkg::COL_W-1:0]     ram_raddr;
    logic [lcm_pkg::WORD_W-1:0]    ram_rdata;

    // Column contents as read; a column not written since reset or clear is blank.
    logic [lcm_pkg::PLANE_W-1:0]   rd_red;
    logic [lcm_pkg::PLANE_W-1:0]   rd_green;
    logic [lcm_pkg::PLANE_W-1:0]   pix_mask;
    logic                          accept;
    logic                          m_take;

    assign rd_red   = r_hit ? ram_rdata[lcm_pkg::PLANE_W-1:0] : '0;
    assign rd_green = r_hit ? ram_rdata[lcm_pkg::WORD_W-1:lcm_pkg::PLANE_W] : '0;
    assign pix_mask = lcm_pkg::PLANE_W'(1) << r_row;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_take        = r_m_valid && m_axis_tready;

    lcm_ram #(
        .WIDTH (lcm_pkg::WORD_W),
        .DEPTH (lcm_pkg::COLUMN_COUNT)
    ) u_planes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Next-state logic: request decode, read-modify-write and byte sequencing.
    always_comb begin
        n_state    = r_state;
        n_valid    = r_valid;
        n_hit      = r_hit;
        n_scan_col = r_scan_col;
        n_lsb      = r_lsb;
        n_col      = r_col;
        n_row      = r_row;
        n_color    = r_color;
        n_even     = r_even;
        n_odd      = r_odd;
        n_pos      = r_pos;
        n_m_valid  = r_m_valid;
        n_m_data   = r_m_data;
        n_m_user   = r_m_user;
        n_m_last   = r_m_last;
        ram_we     = 1'b0;
        ram_waddr  = in_col;
        ram_wdata  = {in_green, in_red};
        ram_raddr  = in_col;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (in_func)
                        lcm_pkg::FUNC_WRITE_COL: begin
                            ram_we          = 1'b1;
                            n_valid[in_col] = 1'b1;
                        end
                        lcm_pkg::FUNC_WRITE_PIX: begin
                            n_hit   = r_valid[in_col];
                            n_col   = in_col;
                            n_row   = in_row;
                            n_color = in_color;
                            n_state = S_PIX;
                        end
                        lcm_pkg::FUNC_CLEAR: begin
                            n_valid = '0;
                        end
                        lcm_pkg::FUNC_SCAN_TICK: begin
                            ram_raddr = r_scan_col;
                            n_hit     = r_valid[r_scan_col];
                            n_state   = S_FETCH;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_PIX: begin
                // Write back the column with the addressed row bit set or cleared.
                ram_we     = 1'b1;
                ram_waddr  = r_col;
                ram_wdata[lcm_pkg::PLANE_W-1:0] =
                    r_color[0] ? (rd_red | pix_mask) : (rd_red & ~pix_mask);
                ram_wdata[lcm_pkg::WORD_W-1:lcm_pkg::PLANE_W] =
                    r_color[1] ? (rd_green | pix_mask) : (rd_green & ~pix_mask);
                n_valid[r_col] = 1'b1;
                n_state    = S_IDLE;
            end
            S_FETCH: begin
                // Build the row interleaves and present the column select byte.
                n_even    = (rd_red & lcm_pkg::EVEN_MASK)
                          | ((rd_green & lcm_pkg::EVEN_MASK) << 1);
                n_odd     = (rd_red & lcm_pkg::ODD_MASK)
                          | ((rd_green & lcm_pkg::ODD_MASK) >> 1);
                n_m_valid = 1'b1;
                n_m_data  = lcm_pkg::col_select(r_scan_col);
                n_m_user  = {1'b1, r_lsb};
                n_m_last  = 1'b0;
                n_pos     = lcm_pkg::BYTE_SELECT;
                n_state   = S_SEND;
            end
            S_SEND: begin
                if (m_take) begin
                    case (r_pos)
                        lcm_pkg::BYTE_SELECT: begin
                            n_m_data = r_even;
                            n_m_user = 2'b00;
                            n_pos    = lcm_pkg::BYTE_EVEN;
                        end
                        lcm_pkg::BYTE_EVEN: begin
                            n_m_data = r_odd;
                            n_m_user = 2'b01;
                            n_m_last = 1'b1;
                            n_pos    = lcm_pkg::BYTE_ODD;
                        end
                        default: begin
                            // Final byte taken: advance the scan column.
                            n_m_valid  = 1'b0;
                            n_m_last   = 1'b0;
                            n_scan_col = r_scan_col + 1'b1;
                            n_lsb      = 1'b1;
                            n_state    = S_IDLE;
                        end
                    endcase
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers with synchronous reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_scan_col <= '0;
            r_lsb      <= 1'b0;
            r_m_valid  <= 1'b0;
            r_pos      <= lcm_pkg::BYTE_SELECT;
        end else begin
            r_state    <= n_state;
            r_valid    <= n_valid;
            r_scan_col <= n_scan_col;
            r_lsb      <= n_lsb;
            r_m_valid  <= n_m_valid;
            r_pos      <= n_pos;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_hit    <= n_hit;
        r_col    <= n_col;
        r_row    <= n_row;
        r_color  <= n_color;
        r_even   <= n_even;
        r_odd    <= n_odd;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
        r_m_last <= n_m_last;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;
    assign m_axis_tlast  = r_m_last;

endmodule
